// File: sv/motion_settle_start_gate_core_macros.svh
// Assertion macros for the motion settle start gate checker.
// Expects clk and rst in the scope where a macro is used.
`ifndef MOTION_SETTLE_START_GATE_CORE_MACROS_SVH
`define MOTION_SETTLE_START_GATE_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MSSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define MSSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mssg_pkg.sv
// Shared types, constants and helpers for the motion settle start gate.
// No dependencies; every module but mssg_sq_lane imports this package.
package mssg_pkg;

  localparam int VELOCITY_BITS_DEF     = 16;
  localparam int TICK_COUNTER_BITS_DEF = 32;
  localparam int CFG_DATA_BITS         = 32;
  localparam int CFG_ADDR_BITS         = 5;
  localparam int RUN_BITS              = 16;
  localparam int LANES                 = 6;
  localparam int LIN_LANES             = 3;

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  // Register reset values
  localparam logic                     GATE_ENABLE_RST   = 1'b0;
  localparam logic [CFG_DATA_BITS-1:0] LINEAR_LIMIT_RST  = 32'd944;
  localparam logic [CFG_DATA_BITS-1:0] ANGULAR_LIMIT_RST = 32'd2621;
  localparam logic [CFG_DATA_BITS-1:0] FRESH_TICKS_RST   = 32'd50;
  localparam logic [CFG_DATA_BITS-1:0] MIN_WAIT_RST      = 32'd100;
  localparam logic [CFG_DATA_BITS-1:0] WAIT_LIMIT_RST    = 32'd1500;
  localparam logic [RUN_BITS-1:0]      NEEDED_STABLE_RST = 16'd10;

  // Gate status codes on the result word
  localparam logic [1:0] ST_WAITING = 2'd0;
  localparam logic [1:0] ST_STARTED = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;

  typedef enum logic [2:0] {
    REG_GATE_ENABLE   = 3'd0,
    REG_LINEAR_LIMIT  = 3'd1,
    REG_ANGULAR_LIMIT = 3'd2,
    REG_FRESH_TICKS   = 3'd3,
    REG_MIN_WAIT      = 3'd4,
    REG_WAIT_LIMIT    = 3'd5,
    REG_NEEDED_STABLE = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_WAITING = 3'b001,
    PH_STARTED = 3'b010,
    PH_FAILED  = 3'b100
  } phase_t;

  typedef struct packed {
    logic                     gate_enable;
    logic [CFG_DATA_BITS-1:0] linear_limit_sq;
    logic [CFG_DATA_BITS-1:0] angular_limit_sq;
    logic [CFG_DATA_BITS-1:0] fresh_ticks;
    logic [CFG_DATA_BITS-1:0] min_wait_ticks;
    logic [CFG_DATA_BITS-1:0] wait_limit_ticks;
    logic [RUN_BITS-1:0]      needed_stable;
  } cfg_t;

  typedef struct packed {
    logic sample_present;
    logic sample_bad;
    logic check_now;
  } item_ctl_t;

  function automatic logic [1:0] status_of(phase_t ph);
    logic [1:0] st;
    unique case (ph)
      PH_WAITING: st = ST_WAITING;
      PH_STARTED: st = ST_STARTED;
      PH_FAILED:  st = ST_FAILED;
      default:    st = ST_WAITING;
    endcase
    return st;
  endfunction

endpackage

// File: sv/motion_settle_start_gate_core.sv
// Motion settle start gate: an accepted input word passes the lane squares, merge compare
// and gate update registers in turn to out_valid; it takes one word per cycle while the
// output is not stalled. Each pipeline stage holds or advances on its own, so a
// stalled output word does not block earlier stages until they fill.
// Synchronous reset clears the pipeline and gate state and loads register defaults.
module motion_settle_start_gate_core #(
  parameter int VELOCITY_BITS     = mssg_pkg::VELOCITY_BITS_DEF,
  parameter int TICK_COUNTER_BITS = mssg_pkg::TICK_COUNTER_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // APB-style configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mssg_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [mssg_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [mssg_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  sample_present,
  input  logic                                  sample_bad,
  input  logic signed [VELOCITY_BITS-1:0]       lin_x,
  input  logic signed [VELOCITY_BITS-1:0]       lin_y,
  input  logic signed [VELOCITY_BITS-1:0]       lin_z,
  input  logic signed [VELOCITY_BITS-1:0]       ang_x,
  input  logic signed [VELOCITY_BITS-1:0]       ang_y,
  input  logic signed [VELOCITY_BITS-1:0]       ang_z,
  input  logic                                  check_now,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            gate_status,
  output logic [mssg_pkg::RUN_BITS-1:0]         stable_run
);
  import mssg_pkg::*;

  cfg_t      cfg;
  cfg_reg_t  reg_sel;
  logic      cfg_write;

  logic                       en1, en2, en3;
  logic                       v1, v2;
  item_ctl_t                  ctl1, ctl2;
  logic signed [VELOCITY_BITS-1:0] comp [LANES];
  logic [2*VELOCITY_BITS-1:0] sq [LANES];
  logic                       lin_ok, ang_ok;

  // ---------------- configuration ----------------
  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_enable      <= GATE_ENABLE_RST;
      cfg.linear_limit_sq  <= LINEAR_LIMIT_RST;
      cfg.angular_limit_sq <= ANGULAR_LIMIT_RST;
      cfg.fresh_ticks      <= FRESH_TICKS_RST;
      cfg.min_wait_ticks   <= MIN_WAIT_RST;
      cfg.wait_limit_ticks <= WAIT_LIMIT_RST;
      cfg.needed_stable    <= NEEDED_STABLE_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_GATE_ENABLE:   cfg.gate_enable      <= pwdata[0];
        REG_LINEAR_LIMIT:  cfg.linear_limit_sq  <= pwdata;
        REG_ANGULAR_LIMIT: cfg.angular_limit_sq <= pwdata;
        REG_FRESH_TICKS:   cfg.fresh_ticks      <= pwdata;
        REG_MIN_WAIT:      cfg.min_wait_ticks   <= pwdata;
        REG_WAIT_LIMIT:    cfg.wait_limit_ticks <= pwdata;
        REG_NEEDED_STABLE: cfg.needed_stable    <= pwdata[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GATE_ENABLE:   prdata = CFG_DATA_BITS'(cfg.gate_enable);
      REG_LINEAR_LIMIT:  prdata = cfg.linear_limit_sq;
      REG_ANGULAR_LIMIT: prdata = cfg.angular_limit_sq;
      REG_FRESH_TICKS:   prdata = cfg.fresh_ticks;
      REG_MIN_WAIT:      prdata = cfg.min_wait_ticks;
      REG_WAIT_LIMIT:    prdata = cfg.wait_limit_ticks;
      REG_NEEDED_STABLE: prdata = CFG_DATA_BITS'(cfg.needed_stable);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // a stage advances when it is empty or the stage after it advances
  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1 <= '{sample_present: sample_present, sample_bad: sample_bad,
                check_now: check_now};
    end
    if (en2) begin
      ctl2 <= ctl1;
    end
  end

  // ---------------- squaring lanes ----------------
  assign comp[0] = lin_x;
  assign comp[1] = lin_y;
  assign comp[2] = lin_z;
  assign comp[3] = ang_x;
  assign comp[4] = ang_y;
  assign comp[5] = ang_z;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mssg_sq_lane #(
      .VELOCITY_BITS(VELOCITY_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en1),
      .comp(comp[g]),
      .sq  (sq[g])
    );
  end

  mssg_merge #(
    .VELOCITY_BITS(VELOCITY_BITS)
  ) u_merge (
    .clk   (clk),
    .en    (en2),
    .sq    (sq),
    .cfg   (cfg),
    .lin_ok(lin_ok),
    .ang_ok(ang_ok)
  );

  mssg_gate #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_gate (
    .clk        (clk),
    .rst        (rst),
    .load       (en3 && v2),
    .ctl        (ctl2),
    .lin_ok     (lin_ok),
    .ang_ok     (ang_ok),
    .cfg        (cfg),
    .gate_status(gate_status),
    .stable_run (stable_run)
  );

endmodule

// File: sv/mssg_sq_lane.sv
// One squaring lane: magnitude of a signed velocity component, squared and registered.
// Depends on nothing but its parameter.
module mssg_sq_lane #(
  parameter int VELOCITY_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [VELOCITY_BITS-1:0] comp,
  output logic [2*VELOCITY_BITS-1:0]   sq
);

  logic [VELOCITY_BITS-1:0] mag;

  // Most negative value maps to 2^(N-1), which still fits unsigned
  assign mag = comp[VELOCITY_BITS-1] ? (~comp + 1'b1) : comp;

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= (2*VELOCITY_BITS)'(mag) * (2*VELOCITY_BITS)'(mag);
    end
  end

endmodule

// File: sv/mssg_merge.sv
// Merge stage: sums the linear and angular lane squares and compares with the limits.
// Depends on mssg_pkg.
module mssg_merge #(
  parameter int VELOCITY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [2*VELOCITY_BITS-1:0] sq [mssg_pkg::LANES],
  input  mssg_pkg::cfg_t             cfg,
  output logic                       lin_ok,
  output logic                       ang_ok
);
  import mssg_pkg::*;

  localparam int SUM_W = 2 * VELOCITY_BITS + 2;
  localparam int CMP_W = (SUM_W > CFG_DATA_BITS) ? SUM_W : CFG_DATA_BITS;

  logic [SUM_W-1:0] lin_sum;
  logic [SUM_W-1:0] ang_sum;

  always_comb begin
    lin_sum = '0;
    ang_sum = '0;
    for (int i = 0; i < LIN_LANES; i++) begin
      lin_sum = lin_sum + SUM_W'(sq[i]);
      ang_sum = ang_sum + SUM_W'(sq[LIN_LANES + i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_ok <= CMP_W'(lin_sum) <= CMP_W'(cfg.linear_limit_sq);
      ang_ok <= CMP_W'(ang_sum) <= CMP_W'(cfg.angular_limit_sq);
    end
  end

endmodule

// File: sv/mssg_gate.sv
// Gate state: run, elapsed and age counters and the phase machine.
// Its state registers are the result word. Depends on mssg_pkg.
module mssg_gate #(
  parameter int TICK_COUNTER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  mssg_pkg::item_ctl_t           ctl,
  input  logic                          lin_ok,
  input  logic                          ang_ok,
  input  mssg_pkg::cfg_t                cfg,
  output logic [1:0]                    gate_status,
  output logic [mssg_pkg::RUN_BITS-1:0] stable_run
);
  import mssg_pkg::*;

  localparam int CMP_W = (TICK_COUNTER_BITS > CFG_DATA_BITS) ? TICK_COUNTER_BITS
                                                              : CFG_DATA_BITS;

  phase_t                       phase, phase_next;
  logic [RUN_BITS-1:0]          run_count, run_next;
  logic [TICK_COUNTER_BITS-1:0] elapsed_count, elapsed_next;
  logic [TICK_COUNTER_BITS-1:0] sample_age, age_next;
  logic                         seen_sample, seen_next;
  logic                         fresh;

  always_comb begin
    phase_next   = phase;
    run_next     = run_count;
    elapsed_next = elapsed_count;
    age_next     = sample_age;
    seen_next    = seen_sample;
    fresh        = 1'b0;
    if (phase == PH_WAITING) begin
      if (!cfg.gate_enable) begin
        phase_next = PH_STARTED;
      end else begin
        // saturate the tick counters
        if (!(&elapsed_count)) begin
          elapsed_next = elapsed_count + 1'b1;
        end
        if (seen_sample && !(&sample_age)) begin
          age_next = sample_age + 1'b1;
        end
        if (ctl.sample_present) begin
          age_next  = '0;
          seen_next = 1'b1;
          if (ctl.sample_bad || !(lin_ok && ang_ok)) begin
            run_next = '0;
          end else if (run_count != RUN_MAX) begin
            run_next = run_count + 1'b1;
          end
        end
        if (ctl.check_now) begin
          fresh = seen_next && (CMP_W'(age_next) <= CMP_W'(cfg.fresh_ticks));
          // a stale sample drops the run; no sample yet leaves it alone
          if (seen_next && !fresh) begin
            run_next = '0;
          end
          if (fresh && (CMP_W'(elapsed_next) >= CMP_W'(cfg.min_wait_ticks)) &&
              (run_next >= cfg.needed_stable)) begin
            phase_next = PH_STARTED;
          end else if (CMP_W'(elapsed_next) > CMP_W'(cfg.wait_limit_ticks)) begin
            phase_next = PH_FAILED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAITING;
      run_count     <= '0;
      elapsed_count <= '0;
      sample_age    <= '0;
      seen_sample   <= 1'b0;
    end else if (load) begin
      phase         <= phase_next;
      run_count     <= run_next;
      elapsed_count <= elapsed_next;
      sample_age    <= age_next;
      seen_sample   <= seen_next;
    end
  end

  assign gate_status = status_of(phase);
  assign stable_run  = run_count;

endmodule

// File: sv/mssg_checker.sv
// Port-level checker for the motion settle start gate, bound to the top level.
// Depends on mssg_pkg and motion_settle_start_gate_core_macros.svh.
`include "motion_settle_start_gate_core_macros.svh"

module mssg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          pready,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    gate_status,
  input logic [mssg_pkg::RUN_BITS-1:0] stable_run
);
  import mssg_pkg::*;

  logic                have_prev;
  logic [1:0]          last_status;
  logic [RUN_BITS-1:0] last_run;

  // remember the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_valid && !out_stall) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_status <= gate_status;
      last_run    <= stable_run;
    end
  end

  `MSSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(gate_status) && $stable(stable_run), "stalled output word changed")

  `MSSG_ASSERT_NOW(a_pready, psel, pready, "pready low during a transfer")

  `MSSG_ASSERT_NOW(a_final_sticks, out_valid && have_prev && last_status != ST_WAITING, gate_status == last_status && stable_run == last_run, "final status or run changed")

  `MSSG_ASSERT_NOW(a_run_step, out_valid && have_prev, stable_run == '0 || stable_run == last_run || stable_run == last_run + 1'b1, "stable run jumped by more than one")

endmodule

bind motion_settle_start_gate_core mssg_checker u_mssg_checker (.*);

// File: test/settle_gate_checker.sv
// Checker for the motion settle start gate: follows register writes on the APB port,
// predicts the result word of every accepted input word and compares on accept.
// Depends on mssg_pkg for widths, register indexes, status codes and reset values.
module settle_gate_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic                                    pready,
  input  logic [mssg_pkg::CFG_ADDR_BITS-1:0]      paddr,
  input  logic [mssg_pkg::CFG_DATA_BITS-1:0]      pwdata,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic                                    sample_present,
  input  logic                                    sample_bad,
  input  logic signed [mssg_pkg::VELOCITY_BITS_DEF-1:0] lin_x,
  input  logic signed [mssg_pkg::VELOCITY_BITS_DEF-1:0] lin_y,
  input  logic signed [mssg_pkg::VELOCITY_BITS_DEF-1:0] lin_z,
  input  logic signed [mssg_pkg::VELOCITY_BITS_DEF-1:0] ang_x,
  input  logic signed [mssg_pkg::VELOCITY_BITS_DEF-1:0] ang_y,
  input  logic signed [mssg_pkg::VELOCITY_BITS_DEF-1:0] ang_z,
  input  logic                                    check_now,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic [1:0]                              gate_status,
  input  logic [mssg_pkg::RUN_BITS-1:0]           stable_run,
  output int                                      mismatches,
  output int                                      words_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import mssg_pkg::*;

  typedef struct packed {
    logic [1:0]          status;
    logic [RUN_BITS-1:0] run;
  } gate_word_t;

  gate_word_t due_words[$];
  cfg_t       regs;

  // predicted gate state
  logic [1:0]                       status;
  logic [RUN_BITS-1:0]              run_len;
  logic [TICK_COUNTER_BITS_DEF-1:0] ticks;
  logic [TICK_COUNTER_BITS_DEF-1:0] sample_age;
  logic                             have_sample;

  function automatic longint unsigned vel_sq(input logic signed [VELOCITY_BITS_DEF-1:0] v);
    longint w;
    w = longint'(v);
    return w * w;
  endfunction

  task automatic report_field(input string field, input logic [RUN_BITS-1:0] want_v,
                              input logic [RUN_BITS-1:0] got_v);
    mismatches++;
    $error("%s: expected %0d, actual %0d", field, want_v, got_v);
  endtask

  task automatic step_settle_gate(input logic present, input logic bad, input logic check,
                                  input longint unsigned lin_sq, input longint unsigned ang_sq,
                                  output gate_word_t word);
    logic fresh;
    if (status == ST_WAITING) begin
      if (!regs.gate_enable) begin
        status = ST_STARTED;
      end else begin
        if (ticks != '1) ticks = ticks + 1'b1;
        if (have_sample && sample_age != '1) sample_age = sample_age + 1'b1;
        if (present) begin
          sample_age  = '0;
          have_sample = 1'b1;
          if (!bad && lin_sq <= regs.linear_limit_sq && ang_sq <= regs.angular_limit_sq) begin
            if (run_len != RUN_MAX) run_len = run_len + 1'b1;
          end else begin
            run_len = '0;
          end
        end
        if (check) begin
          fresh = have_sample && (sample_age <= regs.fresh_ticks);
          // a stale sample drops the run; no sample at all leaves it
          if (have_sample && !fresh) run_len = '0;
          if (fresh && ticks >= regs.min_wait_ticks && run_len >= regs.needed_stable) begin
            status = ST_STARTED;
          end else if (ticks > regs.wait_limit_ticks) begin
            status = ST_FAILED;
          end
        end
      end
    end
    word.status = status;
    word.run    = run_len;
  endtask

  always @(posedge clk) begin : watch
    gate_word_t want;
    gate_word_t got;
    if (rst) begin
      regs = '{gate_enable: GATE_ENABLE_RST, linear_limit_sq: LINEAR_LIMIT_RST,
               angular_limit_sq: ANGULAR_LIMIT_RST, fresh_ticks: FRESH_TICKS_RST,
               min_wait_ticks: MIN_WAIT_RST, wait_limit_ticks: WAIT_LIMIT_RST,
               needed_stable: NEEDED_STABLE_RST};
      status      = ST_WAITING;
      run_len     = '0;
      ticks       = '0;
      sample_age  = '0;
      have_sample = 1'b0;
      mismatches  = 0;
      due_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]))
          REG_GATE_ENABLE:   regs.gate_enable      = pwdata[0];
          REG_LINEAR_LIMIT:  regs.linear_limit_sq  = pwdata;
          REG_ANGULAR_LIMIT: regs.angular_limit_sq = pwdata;
          REG_FRESH_TICKS:   regs.fresh_ticks      = pwdata;
          REG_MIN_WAIT:      regs.min_wait_ticks   = pwdata;
          REG_WAIT_LIMIT:    regs.wait_limit_ticks = pwdata;
          REG_NEEDED_STABLE: regs.needed_stable    = pwdata[RUN_BITS-1:0];
          default: ;
        endcase
      end
      // results leave only after their word has passed the pipeline registers, so pop before push
      if (out_valid && !out_stall) begin
        got.status = gate_status;
        got.run    = stable_run;
        if (due_words.size() == 0) begin
          mismatches++;
          $error("result word with nothing expected: gate_status %0d, stable_run %0d",
                 gate_status, stable_run);
        end else begin
          want = due_words.pop_front();
          if (got.status !== want.status) begin
            report_field("gate_status", RUN_BITS'(want.status), RUN_BITS'(got.status));
          end
          if (got.run !== want.run) report_field("stable_run", want.run, got.run);
        end
      end
      if (in_valid && !in_stall) begin
        step_settle_gate(sample_present, sample_bad, check_now,
                         vel_sq(lin_x) + vel_sq(lin_y) + vel_sq(lin_z),
                         vel_sq(ang_x) + vel_sq(ang_y) + vel_sq(ang_z), want);
        due_words.push_back(want);
      end
    end
    words_due = due_words.size();
  end

endmodule

// File: test/testbench.sv
// Top of the motion settle start gate testbench: clock, reset, APB register writes and
// tick words with random idling on both channels; the checker predicts and compares.
// Depends on mssg_pkg, motion_settle_start_gate_core and settle_gate_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mssg_pkg::*;

  localparam int                       CLK_HALF     = 5;
  localparam int                       DRAIN_SLACK  = 8;
  localparam int                       PHASE_WORDS  = 100;
  localparam int                       STABLE_WORDS = 30;
  localparam logic [CFG_DATA_BITS-1:0] LIMIT_MAX    = 32'd3221225472;
  localparam logic [CFG_DATA_BITS-1:0] ALL_ONES     = '1;

  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              psel           = 1'b0;
  logic                              penable        = 1'b0;
  logic                              pwrite         = 1'b0;
  logic [CFG_ADDR_BITS-1:0]          paddr          = '0;
  logic [CFG_DATA_BITS-1:0]          pwdata         = '0;
  logic [CFG_DATA_BITS-1:0]          prdata;
  logic                              pready;
  logic                              in_valid       = 1'b0;
  logic                              in_stall;
  logic                              sample_present = 1'b0;
  logic                              sample_bad     = 1'b0;
  logic signed [VELOCITY_BITS_DEF-1:0] lin_x = '0;
  logic signed [VELOCITY_BITS_DEF-1:0] lin_y = '0;
  logic signed [VELOCITY_BITS_DEF-1:0] lin_z = '0;
  logic signed [VELOCITY_BITS_DEF-1:0] ang_x = '0;
  logic signed [VELOCITY_BITS_DEF-1:0] ang_y = '0;
  logic signed [VELOCITY_BITS_DEF-1:0] ang_z = '0;
  logic                              check_now      = 1'b0;
  logic                              out_valid;
  logic                              out_stall      = 1'b0;
  logic [1:0]                        gate_status;
  logic [RUN_BITS-1:0]               stable_run;
  int                                mismatches;
  int                                words_due;

  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    words_sent  = 0;
  string finish_path = "none";

  motion_settle_start_gate_core uut (.*);
  settle_gate_checker gate_check (.*);

  always #(CLK_HALF) clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  initial begin
    #(5_000_000);
    $display("timeout with %0d result words outstanding", words_due);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drop valid and hold until every predicted result word has been taken
  task automatic settle();
    in_valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic send_word(input logic present, input logic bad, input logic check,
                           input logic signed [VELOCITY_BITS_DEF-1:0] lx, ly, lz, ax, ay, az);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    sample_present = present;
    sample_bad     = bad;
    check_now      = check;
    lin_x = lx;
    lin_y = ly;
    lin_z = lz;
    ang_x = ax;
    ang_y = ay;
    ang_z = az;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic logic signed [VELOCITY_BITS_DEF-1:0] pick_vel(input bit calm);
    int r;
    r = $urandom_range(99);
    if (calm || r < 40) return VELOCITY_BITS_DEF'($urandom_range(30) - 15);
    if (r < 85) return VELOCITY_BITS_DEF'($urandom());
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic send_random(input bit calm);
    logic present;
    logic bad;
    logic check;
    present = calm ? ($urandom_range(99) < 85) : ($urandom_range(99) < 60);
    bad     = calm ? ($urandom_range(99) < 3) : ($urandom_range(99) < 25);
    check   = $urandom_range(99) < 35;
    send_word(present, bad, check, pick_vel(calm), pick_vel(calm), pick_vel(calm),
              pick_vel(calm), pick_vel(calm), pick_vel(calm));
  endtask

  // mostly runs of quiet samples that build a stable run, with noisy bursts between
  task automatic run_random_phase(input int count);
    int done;
    int burst;
    bit calm;
    done = 0;
    while (done < count) begin
      calm  = $urandom_range(99) < 65;
      burst = $urandom_range(3, 20);
      repeat (burst) begin
        send_random(calm);
        done++;
      end
      if ($urandom_range(99) < 10) settle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // hold the gate open: no start and no timeout until the last phase
    write_reg(REG_GATE_ENABLE, 32'd1);
    write_reg(REG_FRESH_TICKS, 32'd1);
    write_reg(REG_MIN_WAIT, ALL_ONES);
    write_reg(REG_WAIT_LIMIT, ALL_ONES);

    tx_idle_pct = 18;
    rx_idle_pct = 48;
    send_word(0, 0, 1, 0, 0, 0, 0, 0, 0);
    send_word(0, 1, 1, 16'h7FFF, 16'h8000, 0, 0, 16'h7FFF, 16'h8000);
    send_word(1, 0, 1, 0, 0, 0, 0, 0, 0);
    send_word(1, 0, 0, 28, 12, 4, 51, 4, 2);
    send_word(1, 0, 1, -28, -12, -4, -51, -4, -2);
    send_word(1, 0, 0, 28, 12, 5, 0, 0, 0);
    send_word(1, 0, 0, 0, 0, 0, 51, 4, 3);
    send_word(1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(1, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(1, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(1, 0, 0, 1, -1, 0, -1, 1, 0);
    send_word(1, 1, 0, 0, 0, 0, 0, 0, 0);
    send_word(1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(0, 0, 1, 0, 0, 0, 0, 0, 0);
    send_word(1, 0, 1, 0, 0, 0, 0, 0, 0);
    send_word(0, 0, 1, 0, 0, 0, 0, 0, 0);
    send_word(1, 0, 0, 16'h8000, 0, 0, 0, 16'h7FFF, 0);

    settle();
    write_reg(REG_LINEAR_LIMIT, $urandom_range(200, 1200));
    write_reg(REG_ANGULAR_LIMIT, $urandom_range(200, 3000));
    write_reg(REG_FRESH_TICKS, $urandom_range(1, 4));
    write_reg(REG_NEEDED_STABLE, $urandom_range(1, 20));
    run_random_phase(PHASE_WORDS);

    settle();
    tx_idle_pct = 48;
    rx_idle_pct = 18;
    write_reg(REG_LINEAR_LIMIT, 32'd0);
    write_reg(REG_ANGULAR_LIMIT, 32'd0);
    write_reg(REG_FRESH_TICKS, ALL_ONES);
    write_reg(REG_NEEDED_STABLE, 32'd1);
    run_random_phase(PHASE_WORDS);

    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_LINEAR_LIMIT, LIMIT_MAX);
    write_reg(REG_ANGULAR_LIMIT, LIMIT_MAX);
    write_reg(REG_FRESH_TICKS, 32'd2);
    write_reg(REG_NEEDED_STABLE, 32'd3);
    run_random_phase(PHASE_WORDS);

    // every clean sample passes the widest limits: grow one long stable run
    settle();
    write_reg(REG_FRESH_TICKS, ALL_ONES);
    write_reg(REG_NEEDED_STABLE, 32'h0000_FFFF);
    repeat (STABLE_WORDS) begin
      send_word(1, 0, $urandom_range(9) == 0,
                VELOCITY_BITS_DEF'($urandom()), VELOCITY_BITS_DEF'($urandom()),
                VELOCITY_BITS_DEF'($urandom()), VELOCITY_BITS_DEF'($urandom()),
                VELOCITY_BITS_DEF'($urandom()), VELOCITY_BITS_DEF'($urandom()));
    end

    settle();
    case ($urandom_range(2))
      0: begin
        finish_path = "settled start";
        write_reg(REG_NEEDED_STABLE, 32'd0);
        write_reg(REG_MIN_WAIT, 32'd0);
      end
      1: begin
        finish_path = "timeout failure";
        write_reg(REG_WAIT_LIMIT, 32'd1);
      end
      default: begin
        finish_path = "disabled gate";
        write_reg(REG_GATE_ENABLE, 32'd0);
      end
    endcase
    send_word(1, 0, 1, 0, 0, 0, 0, 0, 0);
    // the outcome is final: later samples and checks must not move it
    run_random_phase(20);

    settle();
    $display("covered %0d tick words: edge cases, three limit settings with idling,", words_sent);
    $display("a %0d-word stable burst under wide limits, and a final %s",
             STABLE_WORDS, finish_path);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
